@@ design/xck_pkg.sv @@
// shared types and constants for the xchacha12 keystream xor block
package xck_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned Rounds     = 12;
   localparam int unsigned RoundCntWidth = 4;

   localparam logic [31:0] Sigma0 = 32'h61707865;
   localparam logic [31:0] Sigma1 = 32'h3320646e;
   localparam logic [31:0] Sigma2 = 32'h79622d32;
   localparam logic [31:0] Sigma3 = 32'h6b206574;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_KEY_0   = 3'd0,
      CSR_KEY_1   = 3'd1,
      CSR_KEY_2   = 3'd2,
      CSR_KEY_3   = 3'd3,
      CSR_NONCE_0 = 3'd4,
      CSR_NONCE_1 = 3'd5,
      CSR_NONCE_2 = 3'd6
   } csr_idx_type;

   typedef logic [15:0][31:0] state_type;

   // controller to datapath
   typedef struct packed {
      logic load_hchacha;
      logic load_block;
      logic round_step;
      logic save_subkey;
      logic finish_block;
      logic emit_word;
      logic restart_msg;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_round;
      logic word_wrap;
   } dp_sts_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   // one quarter round on four words
   function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] ta, tb, tc, td;
      ta = a; tb = b; tc = c; td = d;
      ta = ta + tb; td = rotl(td ^ ta, 16);
      tc = tc + td; tb = rotl(tb ^ tc, 12);
      ta = ta + tb; td = rotl(td ^ ta, 8);
      tc = tc + td; tb = rotl(tb ^ tc, 7);
      qround = {ta, tb, tc, td};
   endfunction

   function automatic logic [DataWidth-1:0] byte_mask(input logic [CountWidth-1:0] cnt);
      logic [DataWidth-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (cnt > CountWidth'(i)) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      byte_mask = m;
   endfunction

endpackage

@@ design/xck_if.sv @@
// valid/ready channel interfaces
interface xck_req_if (input logic clock);
   logic                           valid;
   logic                           ready;
   logic [xck_pkg::DataWidth-1:0]  data_in;
   logic [xck_pkg::CountWidth-1:0] byte_count;
   logic                           last;
   modport source (output valid, data_in, byte_count, last, input ready);
   modport sink (input valid, data_in, byte_count, last, output ready);
endinterface

interface xck_rsp_if (input logic clock);
   logic                           valid;
   logic                           ready;
   logic [xck_pkg::DataWidth-1:0]  data_out;
   logic [xck_pkg::CountWidth-1:0] byte_count_out;
   logic                           last_out;
   modport source (output valid, data_out, byte_count_out, last_out, input ready);
   modport sink (input valid, data_out, byte_count_out, last_out, output ready);
endinterface

interface xck_csr_if (input logic clock);
   logic                            valid;
   logic                            ready;
   logic [xck_pkg::CsrIdxWidth-1:0] index;
   logic [xck_pkg::DataWidth-1:0]   wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ design/xck_datapath.sv @@
// chacha state, round unit, keystream buffer and xor stage
module xck_datapath (
   input  logic                              clock,
   input  logic [xck_pkg::DataWidth-1:0]     cfg_key [4],
   input  logic [xck_pkg::DataWidth-1:0]     cfg_nonce [3],
   input  xck_pkg::dp_cmd_type               cmd,
   output xck_pkg::dp_sts_type               sts,
   input  logic [xck_pkg::DataWidth-1:0]     data_in,
   input  logic [xck_pkg::CountWidth-1:0]    byte_count,
   input  logic                              last,
   input  logic                              reset,
   output logic [xck_pkg::DataWidth-1:0]     data_out,
   output logic [xck_pkg::CountWidth-1:0]    byte_count_out,
   output logic                              last_out
);

   xck_pkg::state_type x_ff, x_in, init_ff, init_in, ks_ff, ks_in, rnd;
   logic [7:0][31:0] subkey_ff, subkey_in;
   logic [31:0] ctr_ff, ctr_in;
   logic [2:0]  widx_ff, widx_in;
   logic [xck_pkg::RoundCntWidth-1:0] rcnt_ff, rcnt_in;
   logic [xck_pkg::DataWidth-1:0] dout_ff, dout_in;
   logic [xck_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic last_ff, last_in;
   xck_pkg::state_type hinit, binit;
   logic [127:0] q0, q1, q2, q3;
   logic [63:0] ks_word;

   // one half round: column rounds on even steps, diagonal on odd
   always_comb begin
      rnd = x_ff;
      if (!rcnt_ff[0]) begin
         q0 = xck_pkg::qround(x_ff[0], x_ff[4], x_ff[8],  x_ff[12]);
         q1 = xck_pkg::qround(x_ff[1], x_ff[5], x_ff[9],  x_ff[13]);
         q2 = xck_pkg::qround(x_ff[2], x_ff[6], x_ff[10], x_ff[14]);
         q3 = xck_pkg::qround(x_ff[3], x_ff[7], x_ff[11], x_ff[15]);
         {rnd[0], rnd[4], rnd[8],  rnd[12]} = q0;
         {rnd[1], rnd[5], rnd[9],  rnd[13]} = q1;
         {rnd[2], rnd[6], rnd[10], rnd[14]} = q2;
         {rnd[3], rnd[7], rnd[11], rnd[15]} = q3;
      end else begin
         q0 = xck_pkg::qround(x_ff[0], x_ff[5], x_ff[10], x_ff[15]);
         q1 = xck_pkg::qround(x_ff[1], x_ff[6], x_ff[11], x_ff[12]);
         q2 = xck_pkg::qround(x_ff[2], x_ff[7], x_ff[8],  x_ff[13]);
         q3 = xck_pkg::qround(x_ff[3], x_ff[4], x_ff[9],  x_ff[14]);
         {rnd[0], rnd[5], rnd[10], rnd[15]} = q0;
         {rnd[1], rnd[6], rnd[11], rnd[12]} = q1;
         {rnd[2], rnd[7], rnd[8],  rnd[13]} = q2;
         {rnd[3], rnd[4], rnd[9],  rnd[14]} = q3;
      end
   end

   always_comb begin
      hinit[0] = xck_pkg::Sigma0; hinit[1] = xck_pkg::Sigma1;
      hinit[2] = xck_pkg::Sigma2; hinit[3] = xck_pkg::Sigma3;
      for (int i = 0; i < 4; i++) begin
         hinit[4 + 2*i] = cfg_key[i][31:0];
         hinit[5 + 2*i] = cfg_key[i][63:32];
      end
      hinit[12] = cfg_nonce[0][31:0];  hinit[13] = cfg_nonce[0][63:32];
      hinit[14] = cfg_nonce[1][31:0];  hinit[15] = cfg_nonce[1][63:32];
      binit[0] = xck_pkg::Sigma0; binit[1] = xck_pkg::Sigma1;
      binit[2] = xck_pkg::Sigma2; binit[3] = xck_pkg::Sigma3;
      for (int i = 0; i < 8; i++) begin
         binit[4 + i] = subkey_ff[i];
      end
      binit[12] = ctr_ff;
      binit[13] = '0;
      binit[14] = cfg_nonce[2][31:0];  binit[15] = cfg_nonce[2][63:32];
   end

   always_comb begin
      x_in = x_ff; init_in = init_ff; ks_in = ks_ff; subkey_in = subkey_ff;
      ctr_in = ctr_ff; widx_in = widx_ff; rcnt_in = rcnt_ff;
      dout_in = dout_ff; cnt_in = cnt_ff; last_in = last_ff;
      ks_word = {ks_ff[{widx_ff, 1'b1}], ks_ff[{widx_ff, 1'b0}]};
      if (cmd.restart_msg) begin
         ctr_in = '0; widx_in = '0;
      end
      if (cmd.load_hchacha) begin
         x_in = hinit; rcnt_in = '0;
      end
      if (cmd.load_block) begin
         x_in = binit; init_in = binit; rcnt_in = '0;
      end
      if (cmd.round_step) begin
         x_in = rnd;
         rcnt_in = rcnt_ff + 1'b1;
      end
      if (cmd.save_subkey) begin
         for (int i = 0; i < 4; i++) begin
            subkey_in[i]     = x_ff[i];
            subkey_in[4 + i] = x_ff[12 + i];
         end
      end
      if (cmd.finish_block) begin
         for (int i = 0; i < 16; i++) begin
            ks_in[i] = x_ff[i] + init_ff[i];
         end
      end
      if (cmd.emit_word) begin
         dout_in = (data_in ^ ks_word) & xck_pkg::byte_mask(byte_count);
         cnt_in  = byte_count;
         last_in = last;
         widx_in = widx_ff + 1'b1;
         if (widx_ff == 3'd7) begin
            ctr_in = ctr_ff + 1'b1;
         end
         if (last) begin
            ctr_in = '0; widx_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; init_ff <= init_in; ks_ff <= ks_in;
      dout_ff <= dout_in; cnt_ff <= cnt_in; last_ff <= last_in;
      rcnt_ff <= rcnt_in;
      if (reset) begin
         subkey_ff <= '0; ctr_ff <= '0; widx_ff <= '0;
      end else begin
         subkey_ff <= subkey_in; ctr_ff <= ctr_in; widx_ff <= widx_in;
      end
   end

   // word_wrap: the current beat uses the last word of the block
   assign sts.last_round = (rcnt_ff == xck_pkg::RoundCntWidth'(xck_pkg::Rounds - 1));
   assign sts.word_wrap  = (widx_ff == 3'd7);
   assign data_out       = dout_ff;
   assign byte_count_out = cnt_ff;
   assign last_out       = last_ff;

   a_ctr_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_word && last |=> ctr_ff == '0 && widx_ff == '0)
      else $error("counter not cleared after last beat");
   a_widx_step: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_word && !last |=> widx_ff == $past(widx_ff) + 3'd1)
      else $error("word index did not step");
   a_ctr_step: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_word && !last && widx_ff == 3'd7 |=> ctr_ff == $past(ctr_ff) + 32'd1)
      else $error("block counter did not step");

endmodule

@@ design/xck_ctrl.sv @@
// sequencer for subkey derivation, block generation and beat handshakes
module xck_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output xck_pkg::dp_cmd_type cmd,
   input  xck_pkg::dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_HROUND, S_BLOAD, S_BROUND, S_BFIN, S_READY
   } state_type;

   state_type state_ff, state_in;
   logic in_msg_ff, in_msg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;

   // a beat is taken only with the keystream block ready and the output slot free
   assign take = (state_ff == S_READY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = take;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff; in_msg_in = in_msg_ff; rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!in_msg_ff) begin
                  cmd.load_hchacha = 1'b1;
                  cmd.restart_msg  = 1'b1;
                  state_in = S_HROUND;
               end else begin
                  state_in = S_BLOAD;
               end
            end
         end
         S_HROUND: begin
            cmd.round_step = 1'b1;
            if (sts.last_round) begin
               state_in = S_BLOAD;
            end
         end
         S_BLOAD: begin
            if (!in_msg_ff) begin
               // x holds the final hchacha state; the block load waits until the subkey is saved, in the next cycle
               cmd.save_subkey = 1'b1;
               in_msg_in = 1'b1;
            end else begin
               cmd.load_block = 1'b1;
               state_in = S_BROUND;
            end
         end
         S_BROUND: begin
            cmd.round_step = 1'b1;
            if (sts.last_round) begin
               state_in = S_BFIN;
            end
         end
         S_BFIN: begin
            cmd.finish_block = 1'b1;
            state_in = S_READY;
         end
         S_READY: begin
            if (take && req_valid) begin
               cmd.emit_word = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_last) begin
                  in_msg_in = 1'b0;
                  state_in = S_IDLE;
               end else if (sts.word_wrap) begin
                  state_in = S_BLOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; in_msg_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; in_msg_ff <= in_msg_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("result beat dropped");
   a_ready_state: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_READY)
      else $error("input taken outside ready state");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> state_ff == S_IDLE && !in_msg_ff)
      else $error("message not closed on last beat");

endmodule

@@ design/xchacha12_keystream_xor_top.sv @@
// top level of the xchacha12 keystream xor block
//  channel | dir | payload
//  req     | in  | data_in, byte_count, last
//  rsp     | out | data_out, byte_count_out, last_out
//  csr     | in  | index, wdata (key_0..3, nonce_0..2)
// message start: a load, 12 hchacha half rounds and a subkey save, then each
// 64-byte block takes a load, 12 half rounds of four parallel quarter rounds and
// an add back, and covers eight beats; no beat is taken while a block is made.
// reset clears key, nonce, subkey, block counter and word index.
// a stalled rsp holds the result; req waits until the output slot frees.
module xchacha12_keystream_xor_top (
   input logic clock,
   input logic reset,
   xck_req_if.sink   req,
   xck_rsp_if.source rsp,
   xck_csr_if.sink   csr
);

   logic [xck_pkg::DataWidth-1:0] key_ff [4];
   logic [xck_pkg::DataWidth-1:0] nonce_ff [3];
   xck_pkg::dp_cmd_type cmd, cmd_dp;
   xck_pkg::dp_sts_type sts;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         for (int i = 0; i < 3; i++) nonce_ff[i] <= '0;
      end else if (csr.valid) begin
         unique case (xck_pkg::csr_idx_type'(csr.index))
            xck_pkg::CSR_KEY_0:   key_ff[0] <= csr.wdata;
            xck_pkg::CSR_KEY_1:   key_ff[1] <= csr.wdata;
            xck_pkg::CSR_KEY_2:   key_ff[2] <= csr.wdata;
            xck_pkg::CSR_KEY_3:   key_ff[3] <= csr.wdata;
            xck_pkg::CSR_NONCE_0: nonce_ff[0] <= csr.wdata;
            xck_pkg::CSR_NONCE_1: nonce_ff[1] <= csr.wdata;
            xck_pkg::CSR_NONCE_2: nonce_ff[2] <= csr.wdata;
            default: ;
         endcase
      end
   end

   xck_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_last (req.last), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .cmd, .sts
   );

   always_comb begin
      cmd_dp = cmd;
   end

   xck_datapath u_dp (
      .clock, .reset,
      .cfg_key (key_ff), .cfg_nonce (nonce_ff),
      .cmd (cmd_dp), .sts,
      .data_in (req.data_in), .byte_count (req.byte_count), .last (req.last),
      .data_out (rsp.data_out), .byte_count_out (rsp.byte_count_out),
      .last_out (rsp.last_out)
   );

endmodule
